// ----- rtl/core/aes_rtu_pkg.sv -----
// Package for the AES-128 round transform unit: payload structs, func codes,
// S-box tables and GF(2^8) helpers. No dependencies.
`timescale 1ns / 1ps
package aes_rtu_pkg;

  typedef enum logic [2:0] {
    FUNC_SUB      = 3'd0,
    FUNC_INVSUB   = 3'd1,
    FUNC_SHIFT    = 3'd2,
    FUNC_INVSHIFT = 3'd3,
    FUNC_MIX      = 3'd4,
    FUNC_INVMIX   = 3'd5,
    FUNC_ADDKEY   = 3'd6,
    FUNC_KEYSTEP  = 3'd7
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] state_hi;
    logic [63:0] state_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [3:0]  round_index;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [16] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,
    8'h1b,8'h36,8'h6c,8'hd8,8'hab,8'h4d,8'h9a,8'h2f
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ----- rtl/core/aes_rtu_datapath.sv -----
// Combinational datapath of the AES round transform unit: all eight transforms
// and the result select. Depends on aes_rtu_pkg.
`timescale 1ns / 1ps
module aes_rtu_datapath (
  input  aes_rtu_pkg::in_item_t  item,
  output aes_rtu_pkg::out_item_t res
);
  import aes_rtu_pkg::*;

  logic [7:0] s [16];
  logic [7:0] k [16];
  logic [7:0] o [16];
  logic [7:0] fw [16];
  logic [7:0] iv [16];
  logic [7:0] shf [16];
  logic [7:0] ishf [16];
  logic [7:0] mx [16];
  logic [7:0] imx [16];
  logic [7:0] ks [16];
  logic [7:0] tw [4];
  logic [127:0] st_w, key_w;

  assign st_w  = {item.state_hi, item.state_lo};
  assign key_w = {item.key_hi, item.key_lo};

  // byte index 4*c+r, byte 0 at the top of the word
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i]   = st_w[127 - 8*i -: 8];
      k[i]   = key_w[127 - 8*i -: 8];
      fw[i]  = SBOX[s[i]];
      iv[i]  = INV_SBOX[s[i]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shf[4*c + r]  = s[4*((c + r) % 4) + r];
        ishf[4*c + r] = s[4*((c - r + 4) % 4) + r];
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    logic [7:0] e0, e1, e2, e3, b0, b1, b2, b3, d0, d1, d2, d3, n0, n1, n2, n3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
      z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
      mx[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
      mx[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
      mx[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
      mx[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
      // 14, 11, 13, 9 from the x, x^2, x^3 multiples
      e0 = z0 ^ y0 ^ x0; e1 = z1 ^ y1 ^ x1; e2 = z2 ^ y2 ^ x2; e3 = z3 ^ y3 ^ x3;
      b0 = z0 ^ x0 ^ a0; b1 = z1 ^ x1 ^ a1; b2 = z2 ^ x2 ^ a2; b3 = z3 ^ x3 ^ a3;
      d0 = z0 ^ y0 ^ a0; d1 = z1 ^ y1 ^ a1; d2 = z2 ^ y2 ^ a2; d3 = z3 ^ y3 ^ a3;
      n0 = z0 ^ a0; n1 = z1 ^ a1; n2 = z2 ^ a2; n3 = z3 ^ a3;
      imx[4*c]   = e0 ^ b1 ^ d2 ^ n3;
      imx[4*c+1] = n0 ^ e1 ^ b2 ^ d3;
      imx[4*c+2] = d0 ^ n1 ^ e2 ^ b3;
      imx[4*c+3] = b0 ^ d1 ^ n2 ^ e3;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      tw[r] = SBOX[k[12 + ((r + 1) % 4)]];
    end
    tw[0] = tw[0] ^ RCON[item.round_index];
    for (int r = 0; r < 4; r++) begin
      ks[r] = k[r] ^ tw[r];
    end
    for (int i = 4; i < 16; i++) begin
      ks[i] = k[i] ^ ks[i - 4];
    end
  end

  always_comb begin
    logic [127:0] w;
    for (int i = 0; i < 16; i++) begin
      case (func_t'(item.func))
        FUNC_SUB:      o[i] = fw[i];
        FUNC_INVSUB:   o[i] = iv[i];
        FUNC_SHIFT:    o[i] = shf[i];
        FUNC_INVSHIFT: o[i] = ishf[i];
        FUNC_MIX:      o[i] = mx[i];
        FUNC_INVMIX:   o[i] = imx[i];
        FUNC_ADDKEY:   o[i] = s[i] ^ k[i];
        default:       o[i] = ks[i];
      endcase
    end
    w = '0;
    for (int i = 0; i < 16; i++) begin
      w[127 - 8*i -: 8] = o[i];
    end
    res.result_hi = w[127:64];
    res.result_lo = w[63:0];
  end

endmodule

// ----- rtl/core/aes128_round_transform_unit.sv -----
// AES-128 round transform unit, top level. Path from start to out_valid:
// input register, one pass of table and GF logic, result register.
// Throughput one item per cycle; busy is always low and the receiver cannot
// stall. Synchronous active-low reset clears the valid flags only.
// Depends on aes_rtu_pkg and aes_rtu_datapath.
`timescale 1ns / 1ps
module aes128_round_transform_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  aes_rtu_pkg::in_item_t  in_item,
  output logic                   out_valid,
  output aes_rtu_pkg::out_item_t out_item
);
  import aes_rtu_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r, out_vld_r;
  out_item_t res_nxt, out_r;

  assign busy = 1'b0;

  aes_rtu_datapath u_dp (
    .item (in_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_item;
    end
    out_r <= res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule
